[hdl/storage_latency_channel_scheduler_unit_assert.svh]
// Assertion macros for the channel scheduler.
`ifndef STORAGE_LATENCY_CHANNEL_SCHEDULER_UNIT_ASSERT_SVH
`define STORAGE_LATENCY_CHANNEL_SCHEDULER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SLCS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SLCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SLCS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define SLCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[hdl/slcs_pkg.sv]
`default_nettype none
package slcs_pkg;
   localparam int CHANNELS_DEF = 8;
   localparam int SECTOR_BYTES_DEF = 512;
   localparam int TIME_W = 63;
   localparam int SCALE_W = 13;
   localparam int ACT_W = 4;
   localparam int SECT_W = 33;
   localparam int BYTES_W = 17;
   localparam int BASE_W = 20;
   localparam int CFG_IDX_W = 1;

   localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE = 1'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'd1;

   localparam logic CMD_SUBMIT = 1'b0;
   localparam logic CMD_POLL = 1'b1;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_SIZE = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_NONE = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_MUL, S_COMMIT, S_DEAD, S_DONE
   } state_type;

   localparam int MaxBytes = 65536;

   // Base response time, index {seq, dir, cls}. Each entry is
   // ((1000000000 / rate) * 100) / 1000 for the rate of that class.
   function automatic logic [BASE_W-1:0] base_rom(input logic [4:0] idx);
      logic [BASE_W-1:0] b;
      unique case (idx)
         5'd0: b = 20'd513; 5'd1: b = 20'd527; 5'd2: b = 20'd535; 5'd3: b = 20'd565;
         5'd4: b = 20'd628; 5'd5: b = 20'd705; 5'd6: b = 20'd956; 5'd7: b = 20'd1511;
         5'd8: b = 20'd111358; 5'd9: b = 20'd111234; 5'd10: b = 20'd111358;
         5'd11: b = 20'd116009; 5'd12: b = 20'd128534; 5'd13: b = 20'd125786;
         5'd14: b = 20'd222222; 5'd15: b = 20'd270270;
         5'd16: b = 20'd191; 5'd17: b = 20'd204; 5'd18: b = 20'd232; 5'd19: b = 20'd269;
         5'd20: b = 20'd334; 5'd21: b = 20'd355; 5'd22: b = 20'd680; 5'd23: b = 20'd1390;
         5'd24: b = 20'd920; 5'd25: b = 20'd953; 5'd26: b = 20'd989; 5'd27: b = 20'd1148;
         5'd28: b = 20'd1357; 5'd29: b = 20'd345; 5'd30: b = 20'd697; 5'd31: b = 20'd1370;
         default: b = '0;
      endcase
      return b;
   endfunction
endpackage
`default_nettype wire

[hdl/storage_latency_channel_scheduler_unit.sv]
// Channel     | Ports                          | Handshake
// request     | req_*, start, busy             | start high while busy low
// response    | rsp_*                          | rsp_valid strobe, one cycle
// csr         | csr_we, csr_index, csr_wdata   | write when csr_we high
// While busy, the request scan and the deadline rescan each step through the active
// channels (the active channel count after saturation) via the shared compare unit;
// between them a taken submit passes multiply, commit and setup, a poll passes
// commit and setup, and a rejected submit passes setup only.
// The response strobe rises in the same cycle that busy falls; it cannot be stalled.
// Reset is synchronous and needs no clearing pass.
`default_nettype none
`include "storage_latency_channel_scheduler_unit_assert.svh"
module storage_latency_channel_scheduler_unit #(
   parameter int CHANNELS = slcs_pkg::CHANNELS_DEF,
   parameter int SECTOR_BYTES = slcs_pkg::SECTOR_BYTES_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic req_cmd,
   input  wire logic [slcs_pkg::TIME_W-1:0] req_now_time,
   input  wire logic req_is_write,
   input  wire logic [31:0] req_start_sector,
   input  wire logic [slcs_pkg::BYTES_W-1:0] req_byte_count,
   output logic rsp_valid,
   output logic [1:0] rsp_status,
   output logic [2:0] rsp_channel,
   output logic rsp_sequential,
   output logic [slcs_pkg::TIME_W-1:0] rsp_completion_time,
   output logic [slcs_pkg::TIME_W-1:0] rsp_next_deadline,
   output logic rsp_deadline_valid,
   output logic rsp_channels_full,
   input  wire logic csr_we,
   input  wire logic [slcs_pkg::CFG_IDX_W-1:0] csr_index,
   input  wire logic [slcs_pkg::SCALE_W-1:0] csr_wdata
);
   import slcs_pkg::*;

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W = $clog2(CHANNELS + 1);
   localparam int SB_SHIFT = $clog2(SECTOR_BYTES);

   state_type state_ff, state_in;
   logic [SCALE_W-1:0] scale_ff;
   logic [ACT_W-1:0] act_ff;

   logic [TIME_W-1:0] done_ff [CHANNELS];
   logic [CHANNELS-1:0] idle_ff;
   logic [CHANNELS-1:0] dir_ff;
   logic [SECT_W-1:0] end_ff [CHANNELS];
   logic [CNT_W-1:0] pend_ff, pend_in;

   logic cmd_ff, wr_ff;
   logic [TIME_W-1:0] now_ff;
   logic [31:0] sect_ff;
   logic [BYTES_W-1:0] bytes_ff;

   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] lim;
   logic seq_ff, seq_in;
   logic found_ff, found_in;
   logic [CH_W-1:0] pick_ff, pick_in;
   logic [TIME_W-1:0] best_ff, best_in;
   logic [TIME_W-1:0] resp_ff;
   logic [1:0] status_ff, status_in;
   logic [TIME_W-1:0] ctime_ff;

   logic [CH_W-1:0] ci;
   logic [TIME_W-1:0] cur_t;
   logic less, scan_end;
   logic [2:0] cls;
   logic [SECT_W-1:0] new_end;
   logic [BYTES_W-1:0] bytes_round;

   assign lim = (int'(act_ff) > CHANNELS) ? CNT_W'(CHANNELS) : CNT_W'(act_ff);
   assign ci = idx_ff[CH_W-1:0];
   assign cur_t = done_ff[ci];
   // The one shared comparator serves both scans.
   assign less = (cur_t < best_ff);
   assign scan_end = (idx_ff >= lim);
   assign bytes_round = req_byte_count;

   always_comb begin
      cls = 3'd7;
      for (int k = 6; k >= 0; k--)
         if (bytes_ff <= BYTES_W'(512 << k)) cls = 3'(k);
   end

   assign new_end = SECT_W'(sect_ff) +
      SECT_W'((BYTES_W + 1)'(bytes_ff) + (BYTES_W + 1)'(SECTOR_BYTES - 1) >> SB_SHIFT);

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      seq_in = seq_ff;
      found_in = found_ff;
      pick_in = pick_ff;
      best_in = best_ff;
      status_in = status_ff;
      pend_in = pend_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SCAN;
               idx_in = '0;
               seq_in = 1'b0;
               found_in = 1'b0;
               pick_in = '0;
               best_in = '0;
               status_in = ST_OK;
            end
         end
         S_SCAN: begin
            if (scan_end) begin
               if (cmd_ff == CMD_SUBMIT) begin
                  if (bytes_ff > BYTES_W'(MaxBytes)) begin
                     status_in = ST_SIZE;
                     state_in = S_DEAD;
                  end else if (!found_ff) begin
                     status_in = ST_FULL;
                     state_in = S_DEAD;
                  end else state_in = S_MUL;
               end else begin
                  status_in = found_ff ? ST_OK : ST_NONE;
                  state_in = S_COMMIT;
               end
            end else begin
               if (cmd_ff == CMD_SUBMIT) begin
                  if (dir_ff[ci] == wr_ff && end_ff[ci] == SECT_W'(sect_ff)) seq_in = 1'b1;
                  if (idle_ff[ci] && (!found_ff || less)) begin
                     found_in = 1'b1; pick_in = ci; best_in = cur_t;
                  end
               end else begin
                  if (!idle_ff[ci] && cur_t < now_ff && (!found_ff || less)) begin
                     found_in = 1'b1; pick_in = ci; best_in = cur_t;
                  end
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         S_MUL: state_in = S_COMMIT;
         S_COMMIT: begin
            if (status_ff == ST_OK) begin
               if (cmd_ff == CMD_SUBMIT) pend_in = pend_ff + 1'b1;
               else if (pend_ff != '0) pend_in = pend_ff - 1'b1;
            end
            state_in = S_DEAD;
            idx_in = '0;
            found_in = 1'b0;
            best_in = '0;
         end
         S_DEAD: begin
            // The scan index restarts here for the deadline pass.
            idx_in = '0;
            found_in = 1'b0;
            best_in = '0;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (scan_end) state_in = S_IDLE;
            else begin
               if (!idle_ff[ci] && (!found_ff || less)) begin
                  found_in = 1'b1; best_in = cur_t;
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         scale_ff <= SCALE_W'(1000);
         act_ff <= ACT_W'(1);
         idle_ff <= '1;
         dir_ff <= '0;
         pend_ff <= '0;
         idx_ff <= '0;
         found_ff <= 1'b0;
         rsp_valid <= 1'b0;
         for (int k = 0; k < CHANNELS; k++) begin
            done_ff[k] <= '0;
            end_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         found_ff <= found_in;
         pend_ff <= pend_in;
         rsp_valid <= (state_ff == S_DONE) && scan_end;
         if (csr_we) begin
            if (csr_index == CFG_TIME_SCALE) scale_ff <= csr_wdata;
            else if (csr_index == CFG_ACTIVE) act_ff <= csr_wdata[ACT_W-1:0];
         end
         if (state_ff == S_COMMIT && status_ff == ST_OK) begin
            if (cmd_ff == CMD_SUBMIT) begin
               done_ff[pick_ff] <= ctime_ff;
               idle_ff[pick_ff] <= 1'b0;
               dir_ff[pick_ff] <= wr_ff;
               end_ff[pick_ff] <= new_end;
            end else idle_ff[pick_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      seq_ff <= seq_in;
      pick_ff <= pick_in;
      best_ff <= best_in;
      status_ff <= status_in;
      if (state_ff == S_IDLE && start) begin
         cmd_ff <= req_cmd;
         now_ff <= req_now_time;
         wr_ff <= req_is_write;
         sect_ff <= req_start_sector;
         bytes_ff <= bytes_round;
         ctime_ff <= '0;
      end
      if (state_ff == S_SCAN && scan_end)
         resp_ff <= TIME_W'(base_rom({seq_ff, wr_ff, cls}) * scale_ff);
      if (state_ff == S_MUL) ctime_ff <= now_ff + resp_ff;
      if (state_ff == S_SCAN && scan_end && cmd_ff == CMD_POLL)
         ctime_ff <= found_ff ? best_ff : '0;
      if (state_ff == S_DONE && scan_end) begin
         rsp_status <= status_ff;
         rsp_channel <= (status_ff == ST_OK) ? 3'(pick_ff) : 3'd0;
         rsp_sequential <= (status_ff == ST_OK && cmd_ff == CMD_SUBMIT) ? seq_ff : 1'b0;
         rsp_completion_time <= (status_ff == ST_OK) ? ctime_ff : '0;
         rsp_next_deadline <= found_ff ? best_ff : '0;
         rsp_deadline_valid <= found_ff;
         rsp_channels_full <= (pend_ff >= lim);
      end
   end

   assign busy = (state_ff != S_IDLE);

   `SLCS_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "item not taken")
   `SLCS_ASSERT_IMPL(a_pend_range, clock, reset, 1'b1, pend_ff <= CNT_W'(CHANNELS), "pending overflow")
   `SLCS_ASSERT_NEXT(a_rsp_idle, clock, reset, rsp_valid, !rsp_valid, "double response")
   `SLCS_ASSERT_IMPL(a_dl_valid, clock, reset, rsp_valid && !rsp_deadline_valid, rsp_next_deadline == '0, "deadline not cleared")
endmodule
`default_nettype wire
